// ===== design/nsmu_pkg.sv =====
// Shared types, constants and the sigmoid table of the neuron update core.
package nsmu_pkg;

   localparam int DEF_MAX_LINKS = 64;

   localparam logic [15:0] LEARN_RATE_RESET = 16'd9830;
   localparam logic [15:0] MOMENTUM_RESET   = 16'd32768;

   localparam logic REG_LEARN_RATE = 1'b0;
   localparam logic REG_MOMENTUM   = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_FWD  = 2'd1,
      CMD_ADJ  = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic               link_ok;
      logic [5:0]         link_index;
      logic signed [15:0] activation;
      logic signed [15:0] weight_value;
      logic signed [15:0] error_value;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [15:0] learn_rate;
      logic [15:0] momentum;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FWD_MUL,
      ST_FWD_ACC,
      ST_SIG_LOOKUP,
      ST_SIG_OUT,
      ST_ADJ_MUL,
      ST_ADJ_SCALE,
      ST_ADJ_SUM,
      ST_ADJ_ROUND,
      ST_ADJ_WRITE
   } back_state_type;

   // round(4096*sigmoid(k/2)); past the end the curve is flat at its top
   function automatic logic [11:0] sig_table(input logic [4:0] k);
      logic [11:0] v;
      unique case (k)
         5'd0:    v = 12'd2048;
         5'd1:    v = 12'd2550;
         5'd2:    v = 12'd2994;
         5'd3:    v = 12'd3349;
         5'd4:    v = 12'd3608;
         5'd5:    v = 12'd3785;
         5'd6:    v = 12'd3902;
         5'd7:    v = 12'd3976;
         5'd8:    v = 12'd4022;
         5'd9:    v = 12'd4051;
         5'd10:   v = 12'd4069;
         5'd11:   v = 12'd4079;
         5'd12:   v = 12'd4086;
         5'd13:   v = 12'd4090;
         5'd14:   v = 12'd4092;
         5'd15:   v = 12'd4094;
         default: v = 12'd4095;
      endcase
      return v;
   endfunction

endpackage

// ===== design/nsmu_if.sv =====
// Valid/ready channel interfaces for requests and neuron state results.
interface nsmu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         cmd;
   logic [5:0]         link_index;
   logic signed [15:0] activation;
   logic signed [15:0] weight_value;
   logic signed [15:0] error_value;
   logic               last;

   modport source (
      output valid, cmd, link_index, activation, weight_value, error_value, last,
      input  ready
   );
   modport sink (
      input  valid, cmd, link_index, activation, weight_value, error_value, last,
      output ready
   );
endinterface

interface nsmu_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] neuron_state;
   logic        sum_saturated;

   modport source (
      output valid, neuron_state, sum_saturated,
      input  ready
   );
   modport sink (
      input  valid, neuron_state, sum_saturated,
      output ready
   );
endinterface

// ===== design/nsmu_front.sv =====
// Request intake: decodes the command, checks the link and drops no-op requests.
module nsmu_front import nsmu_pkg::*; #(
   parameter int MAX_LINKS = DEF_MAX_LINKS
) (
   nsmu_req_if.sink  req_bus,
   input  logic      queue_full,
   input  logic      clearing,
   output logic      push,
   output item_type  push_item
);

   logic keep;

   always_comb begin
      push_item.cmd          = cmd_type'(req_bus.cmd);
      push_item.link_ok      = 32'(req_bus.link_index) < 32'(MAX_LINKS);
      push_item.link_index   = req_bus.link_index;
      push_item.activation   = req_bus.activation;
      push_item.weight_value = req_bus.weight_value;
      push_item.error_value  = req_bus.error_value;
      push_item.last         = req_bus.last;
   end

   // out-of-range load/adjust/non-last forward and the unused command have no effect
   always_comb begin
      unique case (req_bus.cmd)
         CMD_LOAD: keep = push_item.link_ok;
         CMD_FWD:  keep = push_item.link_ok || req_bus.last;
         CMD_ADJ:  keep = push_item.link_ok;
         default:  keep = 1'b0;
      endcase
   end

   assign req_bus.ready = !queue_full && !clearing;
   assign push          = req_bus.valid && req_bus.ready && keep;

endmodule

// ===== design/nsmu_queue.sv =====
// Two-entry request queue between intake and execution.
module nsmu_queue import nsmu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head_item,
   output logic     full,
   output logic     empty
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign empty     = count_ff == 2'd0;
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/nsmu_back.sv =====
// Executor: link memories, multiply-accumulate, sigmoid and momentum weight update.
module nsmu_back import nsmu_pkg::*; #(
   parameter int MAX_LINKS = DEF_MAX_LINKS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  item_type head_item,
   input  logic     empty,
   output logic     pop,
   output logic     clearing,
   nsmu_rsp_if.source rsp_bus
);

   localparam int LINK_AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int IDX_W   = (LINK_AW > 6) ? LINK_AW : 6;

   back_state_type state_ff, state_in;

   logic signed [15:0] weights [MAX_LINKS];
   logic signed [15:0] deltas  [MAX_LINKS];

   item_type           cur_ff;
   logic signed [15:0] w_rd_ff, d_rd_ff;
   logic signed [39:0] acc_ff, acc_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [31:0] p1_ff;
   logic signed [32:0] p2_ff;
   logic signed [48:0] p3_ff;
   logic signed [48:0] t_ff, t_in;
   logic signed [15:0] d_ff, d_in;
   logic [11:0]        base_ff, base_in;
   logic [8:0]         step_ff, step_in;
   logic [10:0]        frac_ff, frac_in;
   logic               neg_ff, neg_in;
   logic               sat_ff, sat_in;
   logic [12:0]        state_val_ff, state_val_in;
   logic               state_sat_ff;
   logic               rsp_valid_ff;
   logic [LINK_AW-1:0] clr_ff;

   logic [IDX_W-1:0]   head_wide, cur_wide;
   logic [LINK_AW-1:0] head_addr, cur_addr;
   logic               w_we, d_we, out_load;
   logic [LINK_AW-1:0] w_addr, d_addr;
   logic signed [15:0] w_data, d_data, w_new;

   logic [40:0] acc_sum, acc_mag;
   logic [28:0] sig_x;
   logic [15:0] sig_xc;
   logic [11:0] sig_next;
   logic [48:0] t_mag, t_rnd;
   logic [20:0] t_r;
   logic [16:0] w_sum;
   logic [20:0] interp;
   logic [12:0] sig_y;

   assign head_wide = IDX_W'(head_item.link_index);
   assign cur_wide  = IDX_W'(cur_ff.link_index);
   assign head_addr = head_wide[LINK_AW-1:0];
   assign cur_addr  = cur_wide[LINK_AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LINK_AW'(MAX_LINKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               unique case (head_item.cmd)
                  CMD_FWD: state_in = ST_FWD_MUL;
                  CMD_ADJ: state_in = ST_ADJ_MUL;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FWD_MUL:    state_in = ST_FWD_ACC;
         ST_FWD_ACC:    state_in = cur_ff.last ? ST_SIG_LOOKUP : ST_IDLE;
         ST_SIG_LOOKUP: state_in = ST_SIG_OUT;
         ST_SIG_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_ADJ_MUL:    state_in = ST_ADJ_SCALE;
         ST_ADJ_SCALE:  state_in = ST_ADJ_SUM;
         ST_ADJ_SUM:    state_in = ST_ADJ_ROUND;
         ST_ADJ_ROUND:  state_in = ST_ADJ_WRITE;
         ST_ADJ_WRITE:  state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // controls
   always_comb begin
      pop      = 1'b0;
      clearing = 1'b0;
      w_we     = 1'b0;
      d_we     = 1'b0;
      out_load = 1'b0;
      w_addr   = head_addr;
      d_addr   = head_addr;
      w_data   = head_item.weight_value;
      d_data   = 16'sd0;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            d_we     = 1'b1;
            d_addr   = clr_ff;
         end
         ST_IDLE: begin
            pop = !empty;
            if (!empty && head_item.cmd == CMD_LOAD) begin
               w_we = 1'b1;
               d_we = 1'b1;
            end
         end
         ST_SIG_OUT: begin
            out_load = !rsp_valid_ff || rsp_bus.ready;
         end
         ST_ADJ_WRITE: begin
            w_we   = 1'b1;
            d_we   = 1'b1;
            w_addr = cur_addr;
            d_addr = cur_addr;
            w_data = w_new;
            d_data = d_ff;
         end
         default: begin
         end
      endcase
   end

   // forward datapath
   always_comb begin
      prod_in = cur_ff.link_ok ? cur_ff.activation * w_rd_ff : 32'sd0;
      acc_sum = {acc_ff[39], acc_ff} + {{9{prod_ff[31]}}, prod_ff};
      if (acc_sum[40] != acc_sum[39]) begin
         acc_in = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         acc_in = acc_sum[39:0];
      end
   end

   // sigmoid lookup and interpolation
   always_comb begin
      neg_in   = acc_ff[39];
      acc_mag  = neg_in ? -{acc_ff[39], acc_ff} : {acc_ff[39], acc_ff};
      sig_x    = acc_mag[40:12];
      sat_in   = sig_x > 29'd32768;
      sig_xc   = sat_in ? 16'h8000 : sig_x[15:0];
      frac_in  = sig_xc[10:0];
      base_in  = sig_table(sig_xc[15:11]);
      sig_next = sig_table(sig_xc[15:11] + 5'd1);
      step_in  = 9'(sig_next - base_in);
      interp   = 21'(step_ff) * 21'(frac_ff) + 21'd1024;
      sig_y    = 13'(base_ff) + 13'(interp[20:11]);
      state_val_in = neg_ff ? 13'd4096 - sig_y : sig_y;
   end

   // adjust datapath
   always_comb begin
      t_in  = p3_ff + $signed({{4{p2_ff[32]}}, p2_ff, 12'd0});
      t_mag = t_ff[48] ? 49'(-t_ff) : 49'(t_ff);
      t_rnd = t_mag + (49'd1 << 27);
      t_r   = t_rnd[48:28];
      if (!t_ff[48]) begin
         d_in = (t_r > 21'd32767) ? 16'sh7fff : $signed(t_r[15:0]);
      end else begin
         d_in = (t_r > 21'd32768) ? 16'sh8000 : $signed(-t_r[15:0]);
      end
      w_sum = {w_rd_ff[15], w_rd_ff} + {d_ff[15], d_ff};
      if (w_sum[16] != w_sum[15]) begin
         w_new = w_sum[16] ? 16'sh8000 : 16'sh7fff;
      end else begin
         w_new = $signed(w_sum[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= '0;
         state_val_ff <= '0;
         state_sat_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (state_ff == ST_FWD_ACC) begin
            acc_ff <= acc_in;
         end else if (state_ff == ST_SIG_LOOKUP) begin
            acc_ff <= '0;
         end
         if (out_load) begin
            state_val_ff <= state_val_in;
            state_sat_ff <= sat_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_item;
      end
      prod_ff <= prod_in;
      if (state_ff == ST_SIG_LOOKUP) begin
         base_ff <= base_in;
         step_ff <= step_in;
         frac_ff <= frac_in;
         neg_ff  <= neg_in;
         sat_ff  <= sat_in;
      end
      if (state_ff == ST_ADJ_MUL) begin
         p1_ff <= cur_ff.activation * cur_ff.error_value;
         p2_ff <= $signed({1'b0, cfg.momentum}) * d_rd_ff;
      end
      if (state_ff == ST_ADJ_SCALE) begin
         p3_ff <= p1_ff * $signed({1'b0, cfg.learn_rate});
      end
      if (state_ff == ST_ADJ_SUM) begin
         t_ff <= t_in;
      end
      if (state_ff == ST_ADJ_ROUND) begin
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         weights[w_addr] <= w_data;
      end
      if (pop) begin
         w_rd_ff <= weights[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         deltas[d_addr] <= d_data;
      end
      if (pop) begin
         d_rd_ff <= deltas[head_addr];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.neuron_state  = state_val_ff;
   assign rsp_bus.sum_saturated = state_sat_ff;

endmodule

// ===== design/neuron_sigmoid_momentum_update_core.sv =====
// Sigmoid neuron with momentum back-propagation: intake, queue, executor and registers.
// A request is taken whenever the two-entry queue has room, so intake keeps going while
// a result waits on rsp_bus. The executor runs one request at a time through one read
// and one write port per link memory and a chain of registered multipliers; a forward
// step marked last also runs the sigmoid lookup and can wait for the result register.
// Requests that do nothing (unused command, out-of-range load or adjust) are dropped at
// intake. After reset the momentum memory is cleared one link per cycle with
// req_bus.ready low; register writes are taken throughout. learn_rate sits at byte
// address 0 and momentum at 4.
module neuron_sigmoid_momentum_update_core import nsmu_pkg::*; #(
   parameter int MAX_LINKS = DEF_MAX_LINKS
) (
   input  logic        clock,
   input  logic        reset,
   nsmu_req_if.sink    req_bus,
   nsmu_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type  cfg_ff;
   item_type push_item, head_item;
   logic     push, pop, full, empty, clearing;
   logic     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.learn_rate <= LEARN_RATE_RESET;
         cfg_ff.momentum   <= MOMENTUM_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_LEARN_RATE: cfg_ff.learn_rate <= csr_pwdata[15:0];
            REG_MOMENTUM:   cfg_ff.momentum   <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_LEARN_RATE: csr_prdata = {16'd0, cfg_ff.learn_rate};
         REG_MOMENTUM:   csr_prdata = {16'd0, cfg_ff.momentum};
         default:        csr_prdata = 32'd0;
      endcase
   end

   nsmu_front #(
      .MAX_LINKS (MAX_LINKS)
   ) u_front (
      .req_bus    (req_bus),
      .queue_full (full),
      .clearing   (clearing),
      .push       (push),
      .push_item  (push_item)
   );

   nsmu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .full      (full),
      .empty     (empty)
   );

   nsmu_back #(
      .MAX_LINKS (MAX_LINKS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_item (head_item),
      .empty     (empty),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_bus   (rsp_bus)
   );

endmodule
